FILE: rtl/glcm_pkg.sv
// ----------------------------------------------------------------------------
// glcm_pkg
// Shared types, step addresses and the microcode program of the gcd/lcm unit.
// ----------------------------------------------------------------------------
package glcm_pkg;

	localparam int PC_BITS = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_INIT_E,
		OP_DIV_INIT_L,
		OP_DIV_STEP,
		OP_SWAP,
		OP_MUL_INIT,
		OP_MUL_STEP,
		OP_PUT_PROD,
		OP_PUT_GCD,
		OP_PUT_ZERO,
		OP_PUT_OVF
	} op_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_IN_EMPTY,
		C_LCM_ZERO,
		C_Y_ZERO,
		C_MORE,
		C_OVF,
		C_GCD_OP,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t                op;
		cond_t              cond;
		logic [PC_BITS-1:0] target;
		logic               last;
	} ctrl_word_t;

	typedef struct packed {
		logic lcm_zero;
		logic y_zero;
		logic more;
		logic ovf;
		logic gcd_op;
	} flags_t;

	localparam logic [PC_BITS-1:0] A_IDLE     = 4'd0;
	localparam logic [PC_BITS-1:0] A_CHECK    = 4'd1;
	localparam logic [PC_BITS-1:0] A_EUCLID   = 4'd2;
	localparam logic [PC_BITS-1:0] A_EDIV_INI = 4'd3;
	localparam logic [PC_BITS-1:0] A_EDIV     = 4'd4;
	localparam logic [PC_BITS-1:0] A_SWAP     = 4'd5;
	localparam logic [PC_BITS-1:0] A_GDONE    = 4'd6;
	localparam logic [PC_BITS-1:0] A_SELECT   = 4'd7;
	localparam logic [PC_BITS-1:0] A_LDIV_INI = 4'd8;
	localparam logic [PC_BITS-1:0] A_LDIV     = 4'd9;
	localparam logic [PC_BITS-1:0] A_MUL_INI  = 4'd10;
	localparam logic [PC_BITS-1:0] A_MUL      = 4'd11;
	localparam logic [PC_BITS-1:0] A_PUT_PROD = 4'd12;
	localparam logic [PC_BITS-1:0] A_PUT_GCD  = 4'd13;
	localparam logic [PC_BITS-1:0] A_PUT_ZERO = 4'd14;
	localparam logic [PC_BITS-1:0] A_PUT_OVF  = 4'd15;

	function automatic ctrl_word_t rom(input logic [PC_BITS-1:0] addr);
		ctrl_word_t w;
		w = '{op: OP_NOP, cond: C_NONE, target: A_IDLE, last: 1'b1};
		case (addr)
			A_IDLE:     w = '{op: OP_LOAD,       cond: C_IN_EMPTY, target: A_IDLE,     last: 1'b0};
			A_CHECK:    w = '{op: OP_NOP,        cond: C_LCM_ZERO, target: A_PUT_ZERO, last: 1'b0};
			A_EUCLID:   w = '{op: OP_NOP,        cond: C_Y_ZERO,   target: A_GDONE,    last: 1'b0};
			A_EDIV_INI: w = '{op: OP_DIV_INIT_E, cond: C_NONE,     target: A_IDLE,     last: 1'b0};
			A_EDIV:     w = '{op: OP_DIV_STEP,   cond: C_MORE,     target: A_EDIV,     last: 1'b0};
			A_SWAP:     w = '{op: OP_SWAP,       cond: C_ALWAYS,   target: A_EUCLID,   last: 1'b0};
			A_GDONE:    w = '{op: OP_NOP,        cond: C_OVF,      target: A_PUT_OVF,  last: 1'b0};
			A_SELECT:   w = '{op: OP_NOP,        cond: C_GCD_OP,   target: A_PUT_GCD,  last: 1'b0};
			A_LDIV_INI: w = '{op: OP_DIV_INIT_L, cond: C_NONE,     target: A_IDLE,     last: 1'b0};
			A_LDIV:     w = '{op: OP_DIV_STEP,   cond: C_MORE,     target: A_LDIV,     last: 1'b0};
			A_MUL_INI:  w = '{op: OP_MUL_INIT,   cond: C_NONE,     target: A_IDLE,     last: 1'b0};
			A_MUL:      w = '{op: OP_MUL_STEP,   cond: C_MORE,     target: A_MUL,      last: 1'b0};
			A_PUT_PROD: w = '{op: OP_PUT_PROD,   cond: C_OUT_BUSY, target: A_PUT_PROD, last: 1'b1};
			A_PUT_GCD:  w = '{op: OP_PUT_GCD,    cond: C_OUT_BUSY, target: A_PUT_GCD,  last: 1'b1};
			A_PUT_ZERO: w = '{op: OP_PUT_ZERO,   cond: C_OUT_BUSY, target: A_PUT_ZERO, last: 1'b1};
			A_PUT_OVF:  w = '{op: OP_PUT_OVF,    cond: C_OUT_BUSY, target: A_PUT_OVF,  last: 1'b1};
			default:    w = '{op: OP_NOP,        cond: C_NONE,     target: A_IDLE,     last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/glcm_ctrl.sv
// ----------------------------------------------------------------------------
// glcm_ctrl
// Step counter and microcode table; picks the next step from the jump condition.
// ----------------------------------------------------------------------------
module glcm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  glcm_pkg::flags_t flags,
	input  logic             in_valid,
	input  logic             out_busy,
	output glcm_pkg::op_t    op,
	output logic             idle
);

	logic [glcm_pkg::PC_BITS-1:0] pc_q;
	glcm_pkg::ctrl_word_t         word;
	logic                         taken;

	assign word = glcm_pkg::rom(pc_q);
	assign op   = word.op;
	assign idle = (pc_q == glcm_pkg::A_IDLE);

	always_comb begin
		case (word.cond)
			glcm_pkg::C_NONE:     taken = 1'b0;
			glcm_pkg::C_ALWAYS:   taken = 1'b1;
			glcm_pkg::C_IN_EMPTY: taken = !in_valid;
			glcm_pkg::C_LCM_ZERO: taken = flags.lcm_zero;
			glcm_pkg::C_Y_ZERO:   taken = flags.y_zero;
			glcm_pkg::C_MORE:     taken = flags.more;
			glcm_pkg::C_OVF:      taken = flags.ovf;
			glcm_pkg::C_GCD_OP:   taken = flags.gcd_op;
			glcm_pkg::C_OUT_BUSY: taken = out_busy;
			default:              taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= glcm_pkg::A_IDLE;
		end else if (taken) begin
			pc_q <= word.target;
		end else if (word.last) begin
			pc_q <= glcm_pkg::A_IDLE;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

FILE: rtl/glcm_dp.sv
// ----------------------------------------------------------------------------
// glcm_dp
// Datapath: operand magnitudes, euclid registers, bit-serial divider and
// shift-add multiplier, all stepped by the microcode operation.
// ----------------------------------------------------------------------------
module glcm_dp #(
	parameter int N = 32
) (
	input  logic             clk,
	input  glcm_pkg::op_t    op,
	input  logic             operation,
	input  logic [31:0]      operand_a,
	input  logic [31:0]      operand_b,
	output glcm_pkg::flags_t flags,
	output logic [62:0]      result,
	output logic             result_ovf
);

	localparam int CW = $clog2(N + 1);

	logic [N-1:0]   raw_a;
	logic [N-1:0]   raw_b;
	logic [N-1:0]   mag_a;
	logic [N-1:0]   mag_b;
	logic [N-1:0]   ma_q;
	logic [N-1:0]   mb_q;
	logic [N-1:0]   x_q;
	logic [N-1:0]   y_q;
	logic           lcm_q;
	logic [N-1:0]   quo_q;
	logic [N-1:0]   rem_q;
	logic [N-1:0]   div_q;
	logic [CW-1:0]  cnt_q;
	logic [2*N-1:0] prod_q;
	logic [N:0]     trial;
	logic [N:0]     diff;
	logic           fits;
	logic [N:0]     sum;

	assign raw_a = operand_a[N-1:0];
	assign raw_b = operand_b[N-1:0];
	assign mag_a = raw_a[N-1] ? (~raw_a + 1'b1) : raw_a;
	assign mag_b = raw_b[N-1] ? (~raw_b + 1'b1) : raw_b;

	// restoring division, one quotient bit per step
	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	// shift-add multiply, multiplier in the low half of the product
	assign sum = {1'b0, prod_q[2*N-1:N]} + (prod_q[0] ? {1'b0, quo_q} : {(N+1){1'b0}});

	assign flags.lcm_zero = lcm_q && ((ma_q == '0) || (mb_q == '0));
	assign flags.y_zero   = (y_q == '0);
	assign flags.more     = (cnt_q != CW'(1));
	assign flags.ovf      = x_q[N-1];
	assign flags.gcd_op   = !lcm_q;

	always_comb begin
		case (op)
			glcm_pkg::OP_PUT_PROD: result = 63'(prod_q);
			glcm_pkg::OP_PUT_GCD:  result = 63'(x_q);
			default:               result = '0;
		endcase
	end

	assign result_ovf = (op == glcm_pkg::OP_PUT_OVF);

	always_ff @(posedge clk) begin
		case (op)
			glcm_pkg::OP_LOAD: begin
				ma_q  <= mag_a;
				mb_q  <= mag_b;
				x_q   <= mag_a;
				y_q   <= mag_b;
				lcm_q <= operation;
			end
			glcm_pkg::OP_DIV_INIT_E: begin
				quo_q <= x_q;
				div_q <= y_q;
				rem_q <= '0;
				cnt_q <= CW'(N);
			end
			glcm_pkg::OP_DIV_INIT_L: begin
				quo_q <= ma_q;
				div_q <= x_q;
				rem_q <= '0;
				cnt_q <= CW'(N);
			end
			glcm_pkg::OP_DIV_STEP: begin
				rem_q <= fits ? diff[N-1:0] : trial[N-1:0];
				quo_q <= {quo_q[N-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
			end
			glcm_pkg::OP_SWAP: begin
				x_q <= y_q;
				y_q <= rem_q;
			end
			glcm_pkg::OP_MUL_INIT: begin
				prod_q <= {{N{1'b0}}, mb_q};
				cnt_q  <= CW'(N);
			end
			glcm_pkg::OP_MUL_STEP: begin
				prod_q <= {sum, prod_q[N-1:1]};
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/integer_gcd_lcm_unit_top.sv
// ----------------------------------------------------------------------------
// integer_gcd_lcm_unit_top
// Greatest common divisor or least common multiple of two signed operands.
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with operation, operand_a, operand_b; only
// the low OPERAND_BITS bits of each operand are used, sign from the top one.
// output channel: out_valid/out_stall with value and status (overflow when the
// gcd is 2^(OPERAND_BITS-1); value is then 0).
// one transaction is worked on at a time. a microcode sequencer steps a
// bit-serial divider and a shift-add multiplier. gcd runs euclid remainder
// steps until the remainder is zero; lcm then divides the first magnitude by
// the gcd and multiplies the quotient by the second magnitude. a zero operand
// in lcm gives 0 without any euclid steps, and an overflow skips the division
// and multiplication of lcm.
// the next transaction is taken in the cycle after a result is written to the
// output register, even while that result still waits on out_stall; a result
// that cannot be written holds the sequencer at its final step.
// reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module integer_gcd_lcm_unit_top #(
	parameter int OPERAND_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [62:0] value,
	output logic        status
);

	glcm_pkg::op_t    op;
	glcm_pkg::flags_t flags;
	logic             idle;
	logic             out_busy;
	logic             put;
	logic [62:0]      result;
	logic             result_ovf;
	logic             out_valid_q;
	logic [62:0]      value_q;
	logic             status_q;

	assign out_busy = out_valid_q && out_stall;
	assign put = !out_busy && ((op == glcm_pkg::OP_PUT_PROD) || (op == glcm_pkg::OP_PUT_GCD)
		|| (op == glcm_pkg::OP_PUT_ZERO) || (op == glcm_pkg::OP_PUT_OVF));

	glcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.op       (op),
		.idle     (idle)
	);

	glcm_dp #(
		.N (OPERAND_BITS)
	) u_dp (
		.clk        (clk),
		.op         (op),
		.operation  (operation),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.flags      (flags),
		.result     (result),
		.result_ovf (result_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			value_q  <= result;
			status_q <= result_ovf;
		end
	end

	assign in_stall  = !idle;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer took a transaction but did not go busy");

	a_ovf_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> value == 63'd0)
		else $error("overflow result carries a nonzero value");

	a_rise_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("sequencer not idle after writing a result");
`endif

endmodule
